/* rtl/core/vnf_pkg.sv */
`default_nettype none
package vnf_pkg;

  localparam logic [31:0] HASH_X = 32'd374761393;
  localparam logic [31:0] HASH_Y = 32'd668265263;
  localparam logic [31:0] HASH_S = 32'd1274126177;
  localparam logic [31:0] HASH_M = 32'd1103515245;
  localparam logic [31:0] SEED_STEP = 32'd31;

  localparam logic [17:0] SMOOTH_K = 18'd196608;

  localparam logic [31:0] SEED_RST = 32'd0;
  localparam logic [15:0] FREQ_RST = 16'd5243;
  localparam logic [3:0] OCT_RST = 4'd4;

  typedef enum logic [1:0] {
    REG_SEED = 2'd0,
    REG_FREQ = 2'd1,
    REG_OCT  = 2'd2,
    REG_NONE = 2'd3
  } cfg_reg_t;

  // 65536 * 2^(k-1) / (2^k - 1), halves rounded up
  function automatic logic [16:0] recip(input logic [4:0] k);
    logic [16:0] r;
    unique case (k)
      5'd1:    r = 17'd65536;
      5'd2:    r = 17'd43691;
      5'd3:    r = 17'd37449;
      5'd4:    r = 17'd34953;
      5'd5:    r = 17'd33825;
      5'd6:    r = 17'd33288;
      5'd7:    r = 17'd33026;
      5'd8:    r = 17'd32897;
      5'd9:    r = 17'd32832;
      5'd10:   r = 17'd32800;
      5'd11:   r = 17'd32784;
      5'd12:   r = 17'd32776;
      5'd13:   r = 17'd32772;
      5'd14:   r = 17'd32770;
      5'd15:   r = 17'd32769;
      5'd16:   r = 17'd32769;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // a + (b - a) * s / 65536, floored
  function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] s);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [17:0] step;
    logic [17:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, s});
    step = prod[33:16];
    sum = {2'b00, a} + step;
    return sum[15:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/value_noise_fbm.sv */
// value_noise_fbm: fractal value-noise sampler
// input channel: in_valid / in_stall with in_x_coord, in_y_coord; one
//   transfer per sample, a new sample may enter every cycle
// output channel: out_valid / out_stall with out_noise_value, one result
//   per input transfer, in input order
// config: cfg_we, cfg_index, cfg_data; seed (0), base frequency (1),
//   octave count (2); write only while no sample is in flight
// latency: 8 cycles from input transfer to out_valid; throughput one
//   sample per cycle, all octaves run as parallel lanes in a 9 stage pipe
// stall: each stage holds while the stage after it is full and held, so
//   bubbles are squeezed out and in_stall rises only when every stage is
//   full and out_stall is high
// reset: clears all stage valids and loads seed 0, base frequency 5243,
//   octave count 4
`default_nettype none
module value_noise_fbm
  import vnf_pkg::*;
#(
  parameter int MAX_OCTAVES = 8,
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_x_coord,
  input  wire logic [COORD_BITS-1:0] in_y_coord,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [15:0]                out_noise_value,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);

  localparam int NS = 9;
  localparam int MW = COORD_BITS + 16;
  localparam int SW = MW + MAX_OCTAVES + 32;
  localparam int SUM_W = 34;
  localparam logic [4:0] KMAX = 5'(MAX_OCTAVES);

  logic [31:0] seed_r;
  logic [15:0] freq_r;
  logic [3:0]  oct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RST;
      freq_r <= FREQ_RST;
      oct_r <= OCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEED: seed_r <= cfg_data;
        REG_FREQ: freq_r <= cfg_data[15:0];
        REG_OCT:  oct_r <= cfg_data[3:0];
        REG_NONE: ;
        default:  ;
      endcase
    end
  end

  logic [4:0] keff;
  always_comb begin
    if (oct_r == 4'd0) keff = 5'd1;
    else if ({1'b0, oct_r} > KMAX) keff = KMAX;
    else keff = {1'b0, oct_r};
  end

  // valid chain and per-stage load enables
  logic [NS:1] vld_r;
  logic [NS:1] rdy;
  always_comb begin
    rdy[NS] = !vld_r[NS] || !out_stall;
    for (int j = NS - 1; j >= 1; j--) rdy[j] = !vld_r[j] || rdy[j+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_valid;
      for (int j = 2; j <= NS; j++) begin
        if (rdy[j]) vld_r[j] <= vld_r[j-1];
      end
    end
  end

  assign in_stall = !rdy[1];
  assign out_valid = vld_r[NS];

  // stage 1: scaled coordinates
  logic [MW-1:0] mx_r, my_r;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      mx_r <= in_x_coord * freq_r;
      my_r <= in_y_coord * freq_r;
    end
  end

  logic [15:0] smp_r [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    localparam logic [31:0] SOFS = 32'(i) * SEED_STEP;

    logic [31:0] sc1_r;
    always_ff @(posedge clk) begin
      if (rdy[1]) sc1_r <= (seed_r + SOFS) * HASH_S;
    end

    // stage 2: corner integers and fractions
    logic [SW-1:0] shx, shy;
    logic [31:0] ix, iy;
    logic [15:0] dx, dy;
    assign shx = {{(SW-MW){1'b0}}, mx_r} << i;
    assign shy = {{(SW-MW){1'b0}}, my_r} << i;
    assign ix = shx[47:16];
    assign iy = shy[47:16];
    assign dx = shx[15:0];
    assign dy = shy[15:0];

    logic [31:0] xa_r, yb_r, sc2_r, dx2_r, dy2_r;
    logic [15:0] dx_r, dy_r;
    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        xa_r <= ix * HASH_X;
        yb_r <= iy * HASH_Y;
        sc2_r <= sc1_r;
        dx2_r <= dx * dx;
        dy2_r <= dy * dy;
        dx_r <= dx;
        dy_r <= dy;
      end
    end

    // stage 3: corner hash sums and smoothstep weights
    logic [31:0] h00, h10, h01, h11;
    logic [49:0] smx, smy;
    assign h00 = xa_r + yb_r + sc2_r;
    assign h10 = h00 + HASH_X;
    assign h01 = h00 + HASH_Y;
    assign h11 = h10 + HASH_Y;
    assign smx = dx2_r * (SMOOTH_K - {1'b0, dx_r, 1'b0});
    assign smy = dy2_r * (SMOOTH_K - {1'b0, dy_r, 1'b0});

    logic [31:0] g00_r, g10_r, g01_r, g11_r;
    logic [15:0] sx3_r, sy3_r;
    always_ff @(posedge clk) begin
      if (rdy[3]) begin
        g00_r <= h00 ^ (h00 >> 13);
        g10_r <= h10 ^ (h10 >> 13);
        g01_r <= h01 ^ (h01 >> 13);
        g11_r <= h11 ^ (h11 >> 13);
        sx3_r <= smx[47:32];
        sy3_r <= smy[47:32];
      end
    end

    // stage 4: hash multiply
    logic [31:0] m00_r, m10_r, m01_r, m11_r;
    logic [15:0] sx4_r, sy4_r;
    always_ff @(posedge clk) begin
      if (rdy[4]) begin
        m00_r <= g00_r * HASH_M;
        m10_r <= g10_r * HASH_M;
        m01_r <= g01_r * HASH_M;
        m11_r <= g11_r * HASH_M;
        sx4_r <= sx3_r;
        sy4_r <= sy3_r;
      end
    end

    // stage 5: corner values and horizontal blend
    logic [15:0] n00, n10, n01, n11;
    assign n00 = m00_r[15:0] ^ m00_r[31:16];
    assign n10 = m10_r[15:0] ^ m10_r[31:16];
    assign n01 = m01_r[15:0] ^ m01_r[31:16];
    assign n11 = m11_r[15:0] ^ m11_r[31:16];

    logic [15:0] top_r, bot_r, sy5_r;
    always_ff @(posedge clk) begin
      if (rdy[5]) begin
        top_r <= lerp(n00, n10, sx4_r);
        bot_r <= lerp(n01, n11, sx4_r);
        sy5_r <= sy4_r;
      end
    end

    // stage 6: vertical blend
    always_ff @(posedge clk) begin
      if (rdy[6]) smp_r[i] <= lerp(top_r, bot_r, sy5_r);
    end
  end

  // stage 7: weighted octave sum
  logic [SUM_W-1:0] wsum;
  always_comb begin
    wsum = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (5'(i) < keff) wsum = wsum + (SUM_W'(smp_r[i]) << (16 - i));
    end
  end

  logic [SUM_W-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (rdy[7]) sum_r <= wsum;
  end

  // stage 8: normalize by total weight
  logic [SUM_W+16:0] prod_r;
  always_ff @(posedge clk) begin
    if (rdy[8]) prod_r <= sum_r * recip(keff);
  end

  // stage 9: saturate into the output register
  logic [SUM_W-16:0] scaled;
  assign scaled = prod_r[SUM_W+16:32];

  logic [15:0] res_r;
  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      if (scaled > (SUM_W-15)'(16'hFFFF)) res_r <= 16'hFFFF;
      else res_r <= scaled[15:0];
    end
  end

  assign out_noise_value = res_r;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[1])
    else $error("accepted sample did not enter stage 1");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&vld_r)))
    else $error("input stalled without a full, held pipeline");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

/* verif/value_noise_fbm_test.sv */
`default_nettype none
module value_noise_fbm_test;
  import vnf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class noise_scoreboard;
    logic [31:0] seed;
    logic [15:0] freq;
    logic [3:0]  octaves;
    logic [15:0] pending[$];

    function new();
      seed = SEED_RST;
      freq = FREQ_RST;
      octaves = OCT_RST;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        REG_SEED: seed = data;
        REG_FREQ: freq = data[15:0];
        REG_OCT:  octaves = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] corner(logic [31:0] cx, logic [31:0] cy, logic [31:0] s);
      logic [31:0] h;
      h = cx * HASH_X + cy * HASH_Y + s * HASH_S;
      h = (h ^ (h >> 13)) * HASH_M;
      h = h ^ (h >> 16);
      return {48'd0, h[15:0]};
    endfunction

    function logic [63:0] smooth(logic [63:0] d);
      return (d * d * (64'd196608 - 64'd2 * d)) >> 32;
    endfunction

    function logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] s);
      return (a * (64'd65536 - s) + b * s) >> 16;
    endfunction

    function logic [63:0] octave(logic [63:0] x, logic [63:0] y, logic [63:0] f,
                                 logic [31:0] s);
      logic [63:0] px, py, sx, sy, top, bot;
      logic [31:0] ix, iy;
      px = x * f;
      py = y * f;
      ix = px[47:16];
      iy = py[47:16];
      sx = smooth({48'd0, px[15:0]});
      sy = smooth({48'd0, py[15:0]});
      top = mix(corner(ix, iy, s), corner(ix + 1, iy, s), sx);
      bot = mix(corner(ix, iy + 1, s), corner(ix + 1, iy + 1, s), sx);
      return mix(top, bot, sy);
    endfunction

    function void note(logic [15:0] x, logic [15:0] y);
      int k;
      logic [63:0] sum, den, num, r, res;
      k = octaves;
      if (k < 1) k = 1;
      if (k > 8) k = 8;
      sum = 0;
      for (int i = 0; i < k; i++)
        sum += octave({48'd0, x}, {48'd0, y}, {48'd0, freq} << i, seed + SEED_STEP * i)
               * (64'd65536 >> i);
      den = (64'd1 << k) - 1;
      num = 64'd1 << (k + 16);
      r = (num + den) / (2 * den);
      res = (sum * r) >> 32;
      if (res > 65535) res = 65535;
      pending = {pending, res[15:0]};
    endfunction

    function bit check(logic [15:0] got, output logic [15:0] want, output bit orphan);
      orphan = (pending.size() == 0);
      want = 'x;
      if (orphan) return 0;
      want = pending.pop_front();
      return got === want;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] in_x_coord = 0;
  logic [15:0] in_y_coord = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_noise_value;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  noise_scoreboard sb = new();
  int errors = 0;
  int quiet_cycles = 0;
  bit quiet = 0;
  bit hold_req = 0;

  value_noise_fbm dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_stall(out_stall), .out_noise_value(out_noise_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [15:0] want;
    bit orphan;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        sb.note(in_x_coord, in_y_coord);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (!sb.check(out_noise_value, want, orphan))
          report(orphan ? "unexpected transfer" : "noise_value", out_noise_value, want);
      end
      if (quiet_cycles >= 5000) begin
        $display("FAIL value_noise_fbm");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (100) @(negedge clk);
        hold_req = 0;
        out_stall = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(logic [15:0] x, logic [15:0] y);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_x_coord = x;
    in_y_coord = y;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++)
      send(16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset settings, coordinate extremes
    send(16'h0000, 16'h0000);
    send(16'hffff, 16'hffff);
    send(16'h0000, 16'hffff);
    send(16'hffff, 16'h0000);
    send(16'h5555, 16'haaaa);
    send(16'haaaa, 16'h5555);
    drain();

    write_reg(REG_SEED, 32'h0);
    write_reg(REG_FREQ, 32'd1);
    write_reg(REG_OCT, 32'd1);
    send(16'h0000, 16'h0000);
    send(16'hffff, 16'hffff);
    send(16'h8000, 16'h0001);
    drain();

    write_reg(REG_SEED, 32'hffffffff);
    write_reg(REG_FREQ, 32'hffffffff);
    write_reg(REG_OCT, 32'd8);
    send(16'hffff, 16'hffff);
    send(16'h0001, 16'hfffe);
    send(16'h0000, 16'h0000);
    drain();

    // zero octave count, above max octave count, zero frequency, ignored index
    write_reg(REG_OCT, 32'd0);
    send(16'h1234, 16'h4321);
    drain();
    write_reg(REG_OCT, 32'hfffffff);
    send(16'h1234, 16'h4321);
    drain();
    write_reg(REG_FREQ, 32'h0);
    send(16'hffff, 16'h7777);
    send(16'h0000, 16'h0001);
    drain();
    write_reg(REG_NONE, $urandom);
    send(16'hbeef, 16'hcafe);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_SEED, $urandom);
      write_reg(REG_FREQ, (p == 0) ? 32'hffff : $urandom);
      write_reg(REG_OCT, (p == 1) ? 32'd8 : $urandom);
      if (p == 2) hold_req = 1;
      if (p == 7) quiet = 1;
      random_items(85);
      drain();
    end

    if (errors == 0) begin
      $display("PASS value_noise_fbm");
    end else begin
      $display("FAIL value_noise_fbm");
    end
    $finish;
  end
endmodule
`default_nettype wire
